// ----- hw/rtl/snps_pkg.sv -----
// ----------------------------------------------------------------------------
// snps_pkg
// Shared types and constants of the sparse nibble plane store.
// ----------------------------------------------------------------------------
package snps_pkg;

  localparam int unsigned LAYERS      = 128;
  localparam int unsigned LAYER_W     = $clog2(LAYERS);
  localparam int unsigned PLANE_BYTES = 128;
  localparam int unsigned BYTE_W      = $clog2(PLANE_BYTES);
  // two banks: compress copies surviving planes into the idle bank
  localparam int unsigned PL_DEPTH    = 2 * LAYERS * PLANE_BYTES;
  localparam int unsigned PL_AW       = $clog2(PL_DEPTH);

  typedef enum logic [1:0] {
    MODE_READ     = 2'd0,
    MODE_WRITE    = 2'd1,
    MODE_COMPRESS = 2'd2,
    MODE_FILL     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DARK   = 2'd0,
    KIND_BRIGHT = 2'd1,
    KIND_PLANE  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [LAYER_W-1:0] plane;
  } map_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_PLANE,
    ST_PREFILL,
    ST_C_MAP,
    ST_C_EVAL,
    ST_C_SCAN,
    ST_C_UPD,
    ST_FIN
  } state_e;

  localparam logic [7:0] BYTE_DARK   = 8'h00;
  localparam logic [7:0] BYTE_BRIGHT = 8'hFF;
  localparam logic [3:0] NIB_BRIGHT  = 4'hF;

endpackage

// ----- hw/rtl/snps_if.sv -----
// ----------------------------------------------------------------------------
// snps_req_if / snps_rsp_if
// Valid/ready channels carrying requests and results of the store.
// ----------------------------------------------------------------------------
interface snps_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [3:0] col_x;
  logic [6:0] layer_y;
  logic [3:0] col_z;
  logic [3:0] wr_value;
  logic       fill_bright;

  modport source (output valid, mode, col_x, layer_y, col_z, wr_value, fill_bright,
                  input ready);
  modport sink   (input valid, mode, col_x, layer_y, col_z, wr_value, fill_bright,
                  output ready);
endinterface

interface snps_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] rd_value;
  logic [7:0] planes_used;

  modport source (output valid, rd_value, planes_used, input ready);
  modport sink   (input valid, rd_value, planes_used, output ready);
endinterface

// ----- hw/rtl/sparse_nibble_plane_store.sv -----
// ----------------------------------------------------------------------------
// sparse_nibble_plane_store
// Sparse 16x16xLAYERS store of 4-bit values with on-demand plane allocation.
// ----------------------------------------------------------------------------
// One request at a time. A write that allocates a plane prefills it: the
// prefill writes the 128 plane bytes one per cycle through the single write
// port of the plane RAM. Compress walks the layer map and scans each
// allocated plane, one byte per cycle of scan and copy into the other bank.
// A finished result waits in an output register while the next request is
// taken. No clearing pass after reset: layer map entries carry valid bits
// and plane bytes are always prefilled.
module sparse_nibble_plane_store (
  input  logic       clk_i,
  input  logic       rst_ni,
  snps_req_if.sink   req_i,
  snps_rsp_if.source rsp_o
);
  import snps_pkg::*;

  localparam int unsigned MAP_W = $bits(map_entry_t);

  state_e state_q, state_d;

  // request fields
  mode_e              mode_q, mode_d;
  logic [3:0]         x_q, x_d, z_q, z_d, val_q, val_d;
  logic [LAYER_W-1:0] y_q, y_d;

  // store control
  logic [LAYERS-1:0]  vld_q, vld_d;
  kind_e              fkind_q, fkind_d;
  logic [7:0]         total_q, total_d;
  logic               bank_q, bank_d;
  logic [3:0]         rd_q, rd_d;
  logic [LAYER_W-1:0] plane_q, plane_d;
  logic [7:0]         fb_q, fb_d;
  logic [BYTE_W-1:0]  pf_q, pf_d;

  // compress walk
  logic [LAYER_W:0]   ci_q, ci_d;
  logic [BYTE_W:0]    cj_q, cj_d;
  logic [BYTE_W-1:0]  jd_q, jd_d;
  logic               pend_q, pend_d, zeros_q, zeros_d, ones_q, ones_d;
  logic [7:0]         next_q, next_d;
  logic [LAYER_W-1:0] cpl_q, cpl_d;

  // output register
  logic               ovld_q, ovld_d;
  logic [3:0]         ord_q, ord_d;
  logic [7:0]         oused_q, oused_d;

  // memories
  logic               map_we;
  logic [LAYER_W-1:0] map_waddr, map_raddr;
  map_entry_t         map_wdata, map_rdata, ent;
  logic               pl_we;
  logic [PL_AW-1:0]   pl_waddr, pl_raddr;
  logic [7:0]         pl_wdata, pl_rdata;

  logic               req_acc;
  logic [BYTE_W-1:0]  byte_idx;
  logic [LAYER_W-1:0] ent_idx;

  snps_ram #(.WIDTH(MAP_W), .DEPTH(LAYERS)) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(map_wdata),
    .raddr_i(map_raddr),
    .rdata_o(map_rdata)
  );

  snps_ram #(.WIDTH(8), .DEPTH(PL_DEPTH)) u_plane_ram (
    .clk_i  (clk_i),
    .we_i   (pl_we),
    .waddr_i(pl_waddr),
    .wdata_i(pl_wdata),
    .raddr_i(pl_raddr),
    .rdata_o(pl_rdata)
  );

  // nibble helpers: z[0] picks the high nibble
  function automatic logic [3:0] get_nib(logic [7:0] b, logic hi);
    get_nib = hi ? b[7:4] : b[3:0];
  endfunction

  function automatic logic [7:0] put_nib(logic [7:0] b, logic hi, logic [3:0] v);
    put_nib = hi ? {v, b[3:0]} : {b[7:4], v};
  endfunction

  assign req_acc  = req_i.valid && req_i.ready;
  assign byte_idx = {x_q, z_q[3:1]};

  // map entry seen this cycle; never-written entries read as the fill kind
  assign ent_idx = (state_q == ST_C_EVAL) ? ci_q[LAYER_W-1:0] : y_q;
  always_comb begin
    if (vld_q[ent_idx]) begin
      ent = map_rdata;
    end else begin
      ent.kind  = fkind_q;
      ent.plane = '0;
    end
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = ovld_q;
  assign rsp_o.rd_value    = ord_q;
  assign rsp_o.planes_used = oused_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          unique case (mode_e'(req_i.mode))
            MODE_READ, MODE_WRITE: state_d = ST_MAP;
            MODE_COMPRESS:         state_d = ST_C_MAP;
            MODE_FILL:             state_d = ST_FIN;
            default:               state_d = ST_FIN;
          endcase
        end
      end
      ST_MAP: begin
        if (ent.kind == KIND_PLANE) begin
          state_d = ST_PLANE;
        end else if (mode_q == MODE_READ) begin
          state_d = ST_FIN;
        end else if ((ent.kind == KIND_DARK && val_q == 4'd0) ||
                     (ent.kind == KIND_BRIGHT && val_q == NIB_BRIGHT)) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_PREFILL;
        end
      end
      ST_PLANE: state_d = ST_FIN;
      ST_PREFILL: begin
        if (pf_q == BYTE_W'(PLANE_BYTES - 1)) state_d = ST_FIN;
      end
      ST_C_MAP: begin
        state_d = (ci_q == (LAYER_W + 1)'(LAYERS)) ? ST_FIN : ST_C_EVAL;
      end
      ST_C_EVAL: state_d = (ent.kind == KIND_PLANE) ? ST_C_SCAN : ST_C_MAP;
      ST_C_SCAN: begin
        if (cj_q[BYTE_W] && !pend_q) state_d = ST_C_UPD;
      end
      ST_C_UPD: state_d = ST_C_MAP;
      ST_FIN: begin
        if (!ovld_q || rsp_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mode_d  = mode_q;  x_d = x_q;  z_d = z_q;  val_d = val_q;  y_d = y_q;
    vld_d   = vld_q;   fkind_d = fkind_q;  total_d = total_q;  bank_d = bank_q;
    rd_d    = rd_q;    plane_d = plane_q;  fb_d = fb_q;  pf_d = pf_q;
    ci_d    = ci_q;    cj_d = cj_q;  jd_d = jd_q;  pend_d = pend_q;
    zeros_d = zeros_q; ones_d = ones_q;  next_d = next_q;  cpl_d = cpl_q;
    ovld_d  = ovld_q && !rsp_o.ready;
    ord_d   = ord_q;   oused_d = oused_q;
    map_we    = 1'b0;
    map_waddr = y_q;
    map_wdata = '0;
    map_raddr = ci_q[LAYER_W-1:0];
    pl_we     = 1'b0;
    pl_waddr  = '0;
    pl_wdata  = pl_rdata;
    pl_raddr  = {bank_q, plane_q, byte_idx};

    unique case (state_q)
      ST_IDLE: begin
        map_raddr = req_i.layer_y[LAYER_W-1:0];
        if (req_acc) begin
          mode_d = mode_e'(req_i.mode);
          x_d    = req_i.col_x;
          z_d    = req_i.col_z;
          y_d    = req_i.layer_y[LAYER_W-1:0];
          val_d  = req_i.wr_value;
          rd_d   = 4'd0;
          ci_d   = '0;
          next_d = '0;
          if (mode_e'(req_i.mode) == MODE_FILL) begin
            vld_d   = '0;
            fkind_d = req_i.fill_bright ? KIND_BRIGHT : KIND_DARK;
            total_d = '0;
          end
        end
      end
      ST_MAP: begin
        plane_d  = ent.plane;
        pl_raddr = {bank_q, ent.plane, byte_idx};
        if (ent.kind != KIND_PLANE) begin
          if (mode_q == MODE_READ) begin
            rd_d = (ent.kind == KIND_BRIGHT) ? NIB_BRIGHT : 4'd0;
          end else if (!((ent.kind == KIND_DARK && val_q == 4'd0) ||
                         (ent.kind == KIND_BRIGHT && val_q == NIB_BRIGHT))) begin
            // allocate the next plane
            map_we          = 1'b1;
            map_wdata.kind  = KIND_PLANE;
            map_wdata.plane = total_q[LAYER_W-1:0];
            vld_d[y_q]      = 1'b1;
            total_d         = total_q + 8'd1;
            plane_d         = total_q[LAYER_W-1:0];
            fb_d            = (ent.kind == KIND_BRIGHT) ? BYTE_BRIGHT : BYTE_DARK;
            pf_d            = '0;
          end
        end
      end
      ST_PLANE: begin
        if (mode_q == MODE_READ) begin
          rd_d = get_nib(pl_rdata, z_q[0]);
        end else begin
          pl_we    = 1'b1;
          pl_waddr = {bank_q, plane_q, byte_idx};
          pl_wdata = put_nib(pl_rdata, z_q[0], val_q);
        end
      end
      ST_PREFILL: begin
        // prefill, folding the written nibble into its byte
        pl_we    = 1'b1;
        pl_waddr = {bank_q, plane_q, pf_q};
        pl_wdata = (pf_q == byte_idx) ? put_nib(fb_q, z_q[0], val_q) : fb_q;
        pf_d     = pf_q + BYTE_W'(1);
      end
      ST_C_MAP: begin
        if (ci_q == (LAYER_W + 1)'(LAYERS)) begin
          bank_d  = ~bank_q;
          total_d = next_q;
        end
      end
      ST_C_EVAL: begin
        if (ent.kind == KIND_PLANE) begin
          cpl_d   = ent.plane;
          cj_d    = '0;
          pend_d  = 1'b0;
          zeros_d = 1'b1;
          ones_d  = 1'b1;
        end else begin
          ci_d = ci_q + (LAYER_W + 1)'(1);
        end
      end
      ST_C_SCAN: begin
        // read byte j, copy byte j-1 to the other bank while testing it
        pl_raddr = {bank_q, cpl_q, cj_q[BYTE_W-1:0]};
        pend_d   = !cj_q[BYTE_W];
        jd_d     = cj_q[BYTE_W-1:0];
        if (!cj_q[BYTE_W]) cj_d = cj_q + (BYTE_W + 1)'(1);
        if (pend_q) begin
          pl_we    = 1'b1;
          pl_waddr = {~bank_q, next_q[LAYER_W-1:0], jd_q};
          pl_wdata = pl_rdata;
          if (pl_rdata != BYTE_DARK)   zeros_d = 1'b0;
          if (pl_rdata != BYTE_BRIGHT) ones_d  = 1'b0;
        end
      end
      ST_C_UPD: begin
        map_we    = 1'b1;
        map_waddr = ci_q[LAYER_W-1:0];
        if (zeros_q) begin
          map_wdata.kind = KIND_DARK;
        end else if (ones_q) begin
          map_wdata.kind = KIND_BRIGHT;
        end else begin
          map_wdata.kind  = KIND_PLANE;
          map_wdata.plane = next_q[LAYER_W-1:0];
          next_d          = next_q + 8'd1;
        end
        ci_d = ci_q + (LAYER_W + 1)'(1);
      end
      ST_FIN: begin
        if (!ovld_q || rsp_o.ready) begin
          ovld_d  = 1'b1;
          ord_d   = rd_q;
          oused_d = total_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= '0;
      fkind_q <= KIND_DARK;
      total_q <= '0;
      bank_q  <= 1'b0;
      ovld_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      fkind_q <= fkind_d;
      total_q <= total_d;
      bank_q  <= bank_d;
      ovld_q  <= ovld_d;
      pend_q  <= pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;  x_q <= x_d;  z_q <= z_d;  val_q <= val_d;  y_q <= y_d;
    rd_q    <= rd_d;    plane_q <= plane_d;  fb_q <= fb_d;  pf_q <= pf_d;
    ci_q    <= ci_d;    cj_q <= cj_d;  jd_q <= jd_d;
    zeros_q <= zeros_d; ones_q <= ones_d;  next_q <= next_d;  cpl_q <= cpl_d;
    ord_q   <= ord_d;   oused_q <= oused_d;
  end

endmodule

// ----- hw/rtl/snps_ram.sv -----
// ----------------------------------------------------------------------------
// snps_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module snps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hw/rtl/snps_checker.sv -----
// ----------------------------------------------------------------------------
// snps_checker
// Port-level assertions for the sparse nibble plane store.
// ----------------------------------------------------------------------------
module snps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [3:0] rsp_rd_value_i,
  input logic [7:0] rsp_planes_used_i
);
  import snps_pkg::*;

  // plane count never exceeds the layer count
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_planes_used_i <= 8'(LAYERS)))
    else $error("planes_used above layer count");

  // one request in flight: busy right after a request is taken
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request taken while busy");

  // stalled result stays
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)
    else $error("result dropped under stall");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      ($stable(rsp_rd_value_i) && $stable(rsp_planes_used_i)))
    else $error("result changed under stall");

endmodule

bind sparse_nibble_plane_store snps_checker u_snps_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_rd_value_i   (rsp_o.rd_value),
  .rsp_planes_used_i(rsp_o.planes_used)
);

// ----- test/tb_sparse_nibble_plane_store.sv -----
// ----------------------------------------------------------------------------
// tb_sparse_nibble_plane_store
// Drives random and directed requests into the sparse nibble plane store and
// checks every result against a behavioral copy of the layer map and planes.
// ----------------------------------------------------------------------------
module tb_sparse_nibble_plane_store;
  import snps_pkg::*;

  // Behavioral copy of the store; predicts one result per request
  class plane_store_board;
    kind_e       kinds[LAYERS];
    int unsigned slots[LAYERS];
    logic [7:0]  bytes_q[LAYERS*PLANE_BYTES];
    int unsigned total;
    logic [3:0]  exp_rd[$];
    logic [7:0]  exp_used[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      for (int i = 0; i < LAYERS; i++) begin
        kinds[i] = KIND_DARK;
        slots[i] = 0;
      end
      total = 0;
      errors = 0;
      checked = 0;
    endfunction

    // Repack surviving planes in layer order, uniform planes go back to codes
    function void compress_planes();
      logic [7:0] packed_q[LAYERS*PLANE_BYTES];
      int unsigned next;
      bit zeros, ones;
      next = 0;
      for (int i = 0; i < LAYERS; i++) begin
        if (kinds[i] != KIND_PLANE) continue;
        zeros = 1;
        ones = 1;
        for (int j = 0; j < PLANE_BYTES; j++) begin
          if (bytes_q[slots[i]*PLANE_BYTES+j] != BYTE_DARK) zeros = 0;
          if (bytes_q[slots[i]*PLANE_BYTES+j] != BYTE_BRIGHT) ones = 0;
        end
        if (zeros) kinds[i] = KIND_DARK;
        else if (ones) kinds[i] = KIND_BRIGHT;
        else begin
          for (int j = 0; j < PLANE_BYTES; j++)
            packed_q[next*PLANE_BYTES+j] = bytes_q[slots[i]*PLANE_BYTES+j];
          slots[i] = next;
          next++;
        end
      end
      for (int j = 0; j < next*PLANE_BYTES; j++) bytes_q[j] = packed_q[j];
      total = next;
    endfunction

    function void note_request(mode_e md, logic [3:0] x, logic [6:0] y, logic [3:0] z,
                               logic [3:0] val, logic bright);
      int unsigned pos, idx, sh;
      logic [3:0] rd;
      rd = 4'd0;
      pos = x*16 + z;
      sh = (pos & 1) * 4;
      case (md)
        MODE_READ: begin
          if (kinds[y] == KIND_BRIGHT) rd = NIB_BRIGHT;
          else if (kinds[y] == KIND_PLANE) begin
            idx = slots[y]*PLANE_BYTES + pos/2;
            rd = 4'(bytes_q[idx] >> sh);
          end
        end
        MODE_WRITE: begin
          if (!((kinds[y] == KIND_DARK && val == 0) ||
                (kinds[y] == KIND_BRIGHT && val == NIB_BRIGHT))) begin
            if (kinds[y] != KIND_PLANE) begin
              for (int j = 0; j < PLANE_BYTES; j++)
                bytes_q[total*PLANE_BYTES+j] =
                  (kinds[y] == KIND_BRIGHT) ? BYTE_BRIGHT : BYTE_DARK;
              kinds[y] = KIND_PLANE;
              slots[y] = total;
              total++;
            end
            idx = slots[y]*PLANE_BYTES + pos/2;
            bytes_q[idx] = (bytes_q[idx] & (8'hF0 >> sh)) | (8'(val) << sh);
          end
        end
        MODE_COMPRESS: compress_planes();
        default: begin
          for (int i = 0; i < LAYERS; i++) begin
            kinds[i] = bright ? KIND_BRIGHT : KIND_DARK;
            slots[i] = 0;
          end
          total = 0;
        end
      endcase
      exp_rd.push_back(rd);
      exp_used.push_back(total > 255 ? 8'd255 : 8'(total));
    endfunction

    task automatic report(string what, int unsigned got, int unsigned want);
      $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, checked);
      errors++;
    endtask

    task automatic check_result(logic [3:0] rd, logic [7:0] used);
      logic [3:0] w_rd;
      logic [7:0] w_used;
      checked++;
      if (exp_rd.size() == 0) begin
        $display("MISMATCH unexpected result %0d", checked);
        errors++;
        return;
      end
      w_rd = exp_rd.pop_front();
      w_used = exp_used.pop_front();
      if (rd !== w_rd) report("rd_value", rd, w_rd);
      if (used !== w_used) report("planes_used", used, w_used);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  snps_req_if req_if();
  snps_rsp_if rsp_if();

  sparse_nibble_plane_store DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  plane_store_board board = new();
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned sent;
  int unsigned writes_done, reads_done, compresses_done, fills_done;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.mode = MODE_READ;
    req_if.col_x = 0;
    req_if.layer_y = 0;
    req_if.col_z = 0;
    req_if.wr_value = 0;
    req_if.fill_bright = 0;
    rsp_if.ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    sent = 0;
  end

  // Receiver: random stalls, results checked at the edge
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      board.check_result(rsp_if.rd_value, rsp_if.planes_used);
    rsp_if.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  // Present one request and hold it until accepted
  task automatic send_request(mode_e md, logic [3:0] x, logic [6:0] y, logic [3:0] z,
                              logic [3:0] val, logic bright);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.mode <= md;
    req_if.col_x <= x;
    req_if.layer_y <= y;
    req_if.col_z <= z;
    req_if.wr_value <= val;
    req_if.fill_bright <= bright;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_request(md, x, y, z, val, bright);
    sent++;
    case (md)
      MODE_READ: reads_done++;
      MODE_WRITE: writes_done++;
      MODE_COMPRESS: compresses_done++;
      default: fills_done++;
    endcase
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (board.exp_rd.size() != 0) @(posedge clk_i);
  endtask

  // Random request mix: few compress and fill, writes land on few layers
  task automatic random_requests(int unsigned n);
    int unsigned r;
    logic [6:0] y;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      y = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(7));
      if (r < 45)
        send_request(MODE_WRITE, 4'($urandom), y, 4'($urandom),
                     ($urandom_range(3) == 0) ? (($urandom_range(1)) ? 4'hF : 4'h0)
                                             : 4'($urandom),
                     1'($urandom));
      else if (r < 93)
        send_request(MODE_READ, 4'($urandom), y, 4'($urandom), 4'($urandom), 1'($urandom));
      else if (r < 97)
        send_request(MODE_COMPRESS, 4'($urandom), 7'($urandom), 4'($urandom),
                     4'($urandom), 1'($urandom));
      else
        send_request(MODE_FILL, 4'($urandom), 7'($urandom), 4'($urandom),
                     4'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, matching uniform writes, all modes
    send_request(MODE_READ, 4'hF, 7'd127, 4'hF, 4'h0, 1'b0);
    send_request(MODE_WRITE, 4'h0, 7'd0, 4'h0, 4'h0, 1'b1);
    send_request(MODE_WRITE, 4'h0, 7'd0, 4'h0, 4'hA, 1'b0);
    send_request(MODE_WRITE, 4'h0, 7'd0, 4'h1, 4'h5, 1'b0);
    send_request(MODE_WRITE, 4'hF, 7'd127, 4'hF, 4'hF, 1'b1);
    send_request(MODE_READ, 4'h0, 7'd0, 4'h0, 4'h0, 1'b0);
    send_request(MODE_READ, 4'h0, 7'd0, 4'h1, 4'h0, 1'b0);
    send_request(MODE_READ, 4'hF, 7'd127, 4'hF, 4'h0, 1'b0);
    send_request(MODE_READ, 4'hF, 7'd127, 4'hE, 4'h0, 1'b0);
    send_request(MODE_WRITE, 4'hF, 7'd127, 4'hF, 4'h0, 1'b0);
    send_request(MODE_COMPRESS, 4'hF, 7'd127, 4'hF, 4'hF, 1'b1);
    send_request(MODE_READ, 4'hF, 7'd127, 4'hF, 4'h0, 1'b0);
    send_request(MODE_FILL, 4'h0, 7'd0, 4'h0, 4'h0, 1'b1);
    send_request(MODE_READ, 4'h5, 7'd64, 4'hA, 4'h0, 1'b0);
    send_request(MODE_WRITE, 4'h5, 7'd64, 4'hA, 4'hF, 1'b0);
    send_request(MODE_WRITE, 4'h5, 7'd64, 4'hA, 4'h3, 1'b0);
    send_request(MODE_WRITE, 4'h5, 7'd64, 4'hA, 4'hF, 1'b0);
    send_request(MODE_COMPRESS, 4'h0, 7'd0, 4'h0, 4'h0, 1'b0);
    send_request(MODE_READ, 4'h5, 7'd64, 4'hA, 4'h0, 1'b0);
    send_request(MODE_FILL, 4'hF, 7'd127, 4'hF, 4'hF, 1'b0);
    send_request(MODE_READ, 4'h5, 7'd64, 4'hA, 4'h0, 1'b0);

    // Random phases with varying idle and stall pressure
    random_requests(420);
    drain();
    send_idle_pct = 81;
    random_requests(420);
    send_idle_pct = 0;
    stall_pct = 81;
    random_requests(420);
    send_idle_pct = 15;
    stall_pct = 15;
    random_requests(420);
    drain();
    repeat (300) @(posedge clk_i);

    $display("Sent %0d requests: %0d reads, %0d writes, %0d compress, %0d fill;",
             sent, reads_done, writes_done, compresses_done, fills_done);
    $display("checked %0d results under mixed sender gaps and receiver stalls.",
             board.checked);
    if (board.errors == 0 && board.exp_rd.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Run limit
  initial begin
    #200000000;
    $display("Timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
